### rtl/ptl_pkg.sv
// Shared constants, tables and a helper function for the pan/tilt target locator.
package ptl_pkg;

	localparam int ANGLE_BITS_DEF       = 16;
	localparam int LENGTH_BITS_DEF      = 24;
	localparam int LENGTH_FRAC_BITS_DEF = 16;

	// The sine/cosine unit works on a 32-bit binary angle and gives Q2.30 factors.
	localparam int TRIG_SHIFT   = 30;
	localparam int TRIG_W       = 33;
	localparam int CORDIC_STEPS = 28;
	localparam logic signed [TRIG_W-1:0] CORDIC_START = 33'sd652032874;

	localparam logic [29:0] ATAN_TURNS [CORDIC_STEPS] = '{
		30'd536870912, 30'd316933406, 30'd167458907, 30'd85004756, 30'd42667331,
		30'd21354465, 30'd10679838, 30'd5340245, 30'd2670163, 30'd1335087,
		30'd667544, 30'd333772, 30'd166886, 30'd83443, 30'd41722, 30'd20861,
		30'd10430, 30'd5215, 30'd2608, 30'd1304, 30'd652, 30'd326, 30'd163,
		30'd81, 30'd41, 30'd20, 30'd10, 30'd5
	};

	// Mounting offsets in units of 0.1 mm.
	localparam int BP_X_E4 = 0;
	localparam int BP_Y_E4 = -370;
	localparam int BP_Z_E4 = 1315;
	localparam int PT_X_E4 = 130;
	localparam int PT_Y_E4 = 335;
	localparam int PT_Z_E4 = 553;
	localparam int TS_X_E4 = -164;
	localparam int TS_Y_E4 = 711;
	localparam int TS_Z_E4 = 71;

	// Converts an offset in 0.1 mm to the length grid, rounding half away from zero.
	function automatic longint mount_len(input int e4, input int frac_bits);
		longint mag;
		longint q;
		mag = ((e4 < 0) ? -longint'(e4) : longint'(e4)) <<< frac_bits;
		q = (mag * 2 + 10000) / 20000;
		return (e4 < 0) ? -q : q;
	endfunction

endpackage

### rtl/ptl_in_if.sv
// Input channel carrying one pose and angle word.
interface ptl_in_if #(
	parameter int ANGLE_BITS  = ptl_pkg::ANGLE_BITS_DEF,
	parameter int LENGTH_BITS = ptl_pkg::LENGTH_BITS_DEF
);
	logic                          valid;
	logic                          ready;
	logic signed [LENGTH_BITS-1:0] pos_x;
	logic signed [LENGTH_BITS-1:0] pos_y;
	logic signed [ANGLE_BITS-1:0]  heading;
	logic signed [ANGLE_BITS-1:0]  pan_angle;
	logic signed [ANGLE_BITS-1:0]  tilt_angle;
	logic        [LENGTH_BITS-2:0] target_range;

	modport source (output valid, pos_x, pos_y, heading, pan_angle, tilt_angle, target_range,
		input ready);
	modport sink (input valid, pos_x, pos_y, heading, pan_angle, tilt_angle, target_range,
		output ready);
endinterface

### rtl/ptl_out_if.sv
// Output channel carrying one target position word.
interface ptl_out_if #(
	parameter int LENGTH_BITS = ptl_pkg::LENGTH_BITS_DEF
);
	logic                          valid;
	logic                          ready;
	logic signed [LENGTH_BITS-1:0] target_x;
	logic signed [LENGTH_BITS-1:0] target_y;
	logic signed [LENGTH_BITS-1:0] target_z;

	modport source (output valid, target_x, target_y, target_z, input ready);
	modport sink (input valid, target_x, target_y, target_z, output ready);
endinterface

### rtl/ptl_cordic.sv
// Fully pipelined CORDIC giving cosine and sine of a binary angle in Q2.30.
module ptl_cordic #(
	parameter int ANGLE_BITS = ptl_pkg::ANGLE_BITS_DEF
) (
	input  logic                                 clk,
	input  logic                                 en,
	input  logic [ANGLE_BITS-1:0]                angle,
	output logic signed [ptl_pkg::TRIG_W-1:0]    cos_q,
	output logic signed [ptl_pkg::TRIG_W-1:0]    sin_q
);
	import ptl_pkg::*;

	logic [31:0] b;
	logic [31:0] b_rot;
	logic [31:0] b_fold;
	logic        flip;

	logic signed [TRIG_W-1:0] x_s [CORDIC_STEPS+1];
	logic signed [TRIG_W-1:0] y_s [CORDIC_STEPS+1];
	logic signed [TRIG_W-1:0] z_s [CORDIC_STEPS+1];
	logic                     flip_s [CORDIC_STEPS+1];

	// Fold the angle into [-pi/2, pi/2); results of a folded angle are negated at the end.
	assign b      = {angle, {(32-ANGLE_BITS){1'b0}}};
	assign b_rot  = b + 32'h4000_0000;
	assign flip   = b_rot[31];
	assign b_fold = flip ? (b + 32'h8000_0000) : b;

	always_ff @(posedge clk) begin
		if (en) begin
			x_s[0]    <= CORDIC_START;
			y_s[0]    <= '0;
			z_s[0]    <= {b_fold[31], b_fold};
			flip_s[0] <= flip;
		end
	end

	for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_step
		localparam logic signed [TRIG_W-1:0] ATAN = {3'b000, ATAN_TURNS[i]};
		always_ff @(posedge clk) begin
			if (en) begin
				if (!z_s[i][TRIG_W-1]) begin
					x_s[i+1] <= x_s[i] - (y_s[i] >>> i);
					y_s[i+1] <= y_s[i] + (x_s[i] >>> i);
					z_s[i+1] <= z_s[i] - ATAN;
				end else begin
					x_s[i+1] <= x_s[i] + (y_s[i] >>> i);
					y_s[i+1] <= y_s[i] - (x_s[i] >>> i);
					z_s[i+1] <= z_s[i] + ATAN;
				end
				flip_s[i+1] <= flip_s[i];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			cos_q <= flip_s[CORDIC_STEPS] ? -x_s[CORDIC_STEPS] : x_s[CORDIC_STEPS];
			sin_q <= flip_s[CORDIC_STEPS] ? -y_s[CORDIC_STEPS] : y_s[CORDIC_STEPS];
		end
	end

endmodule

### rtl/pan_tilt_target_locate.sv
// Pan/tilt target locator top level: pose, turret angles and range in, world target position out.
//
// The block takes one word per cycle and gives one result word for each, in order, through the
// three parallel sine/cosine pipelines of 28 CORDIC steps, then seven stages that multiply,
// round and offset through the tilt, pan and heading rotations and finally saturate. The whole
// pipeline advances together: it moves whenever the output register is empty or its word is
// being taken, so a stalled sink freezes every stage and no word is lost or repeated. Lengths
// are signed fixed point with LENGTH_FRAC_BITS fraction bits, angles are binary angles where
// half of the full code range stands for pi, and the three results saturate to the signed
// LENGTH_BITS range. The block holds no state between words.
module pan_tilt_target_locate
	#(
	parameter int ANGLE_BITS       = ptl_pkg::ANGLE_BITS_DEF,
	parameter int LENGTH_BITS      = ptl_pkg::LENGTH_BITS_DEF,
	parameter int LENGTH_FRAC_BITS = ptl_pkg::LENGTH_FRAC_BITS_DEF
) (
	input logic      clk,
	input logic      arst_n,
	ptl_in_if.sink   req,
	ptl_out_if.source rsp
);
	import ptl_pkg::*;

	// Internal length width: headroom for offsets and rotation gain.
	localparam int LW = LENGTH_BITS + 3;
	localparam int PW = LW + TRIG_W;
	localparam int CL = CORDIC_STEPS + 2;
	localparam int NS = CL + 7;

	localparam logic signed [LW-1:0] BP_X = LW'(mount_len(BP_X_E4, LENGTH_FRAC_BITS));
	localparam logic signed [LW-1:0] BP_Y = LW'(mount_len(BP_Y_E4, LENGTH_FRAC_BITS));
	localparam logic signed [LW-1:0] BP_Z = LW'(mount_len(BP_Z_E4, LENGTH_FRAC_BITS));
	localparam logic signed [LW-1:0] PT_X = LW'(mount_len(PT_X_E4, LENGTH_FRAC_BITS));
	localparam logic signed [LW-1:0] PT_Y = LW'(mount_len(PT_Y_E4, LENGTH_FRAC_BITS));
	localparam logic signed [LW-1:0] PT_Z = LW'(mount_len(PT_Z_E4, LENGTH_FRAC_BITS));
	localparam logic signed [LW-1:0] TS_X = LW'(mount_len(TS_X_E4, LENGTH_FRAC_BITS));
	localparam logic signed [LW-1:0] TS_Y = LW'(mount_len(TS_Y_E4, LENGTH_FRAC_BITS));
	localparam logic signed [LW-1:0] TS_Z = LW'(mount_len(TS_Z_E4, LENGTH_FRAC_BITS));
	// The x component is untouched by the tilt, so it is a constant up to the pan.
	localparam logic signed [LW-1:0] TILT_X = TS_X + PT_X;
	localparam logic signed [PW:0]   RND    = (PW+1)'(1) <<< (TRIG_SHIFT - 1);
	localparam logic signed [LW:0]   SAT_HI = (LW+1)'((longint'(1) <<< (LENGTH_BITS-1)) - 1);
	localparam logic signed [LW:0]   SAT_LO = -((LW+1)'(1) <<< (LENGTH_BITS-1));

	logic          en;
	logic [NS-1:0] vld_q;

	logic signed [TRIG_W-1:0] ch, sh, cp, sp, ct, st;

	// Payload that travels beside the sine/cosine pipelines.
	logic signed [LENGTH_BITS-1:0] px_d [CL];
	logic signed [LENGTH_BITS-1:0] py_d [CL];
	logic        [LENGTH_BITS-2:0] rg_d [CL];

	logic signed [LW-1:0]     y0;
	logic signed [PW-1:0]     m_yc_s1, m_zs_s1, m_ys_s1, m_zc_s1;
	logic signed [TRIG_W-1:0] ch_s1, sh_s1, cp_s1, sp_s1;
	logic signed [LENGTH_BITS-1:0] px_s1, py_s1;

	logic signed [LW-1:0]     ty_s2, tz_s2;
	logic signed [TRIG_W-1:0] ch_s2, sh_s2, cp_s2, sp_s2;
	logic signed [LENGTH_BITS-1:0] px_s2, py_s2;

	logic signed [PW-1:0]     m_xc_s3, m_ys_s3, m_xs_s3, m_yc_s3;
	logic signed [LW-1:0]     tz_s3;
	logic signed [TRIG_W-1:0] ch_s3, sh_s3;
	logic signed [LENGTH_BITS-1:0] px_s3, py_s3;

	logic signed [LW-1:0]     qx_s4, qy_s4, qz_s4;
	logic signed [TRIG_W-1:0] ch_s4, sh_s4;
	logic signed [LENGTH_BITS-1:0] px_s4, py_s4;

	logic signed [PW-1:0]     m_xc_s5, m_ys_s5, m_xs_s5, m_yc_s5;
	logic signed [LW-1:0]     qz_s5;
	logic signed [LENGTH_BITS-1:0] px_s5, py_s5;

	logic signed [LW:0]       hx_s6, hy_s6, hz_s6;

	// Rounds a sum of length-by-factor products back onto the length grid.
	function automatic logic signed [LW-1:0] rnd(input logic signed [PW:0] v);
		logic signed [PW:0] t;
		t = (v + RND) >>> TRIG_SHIFT;
		return t[LW-1:0];
	endfunction

	function automatic logic signed [LENGTH_BITS-1:0] sat(input logic signed [LW:0] v);
		logic signed [LW:0] t;
		t = (v > SAT_HI) ? SAT_HI : ((v < SAT_LO) ? SAT_LO : v);
		return t[LENGTH_BITS-1:0];
	endfunction

	assign en        = !vld_q[NS-1] || rsp.ready;
	assign req.ready = en;
	assign rsp.valid = vld_q[NS-1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (en) begin
			vld_q <= {vld_q[NS-2:0], req.valid};
		end
	end

	ptl_cordic #(.ANGLE_BITS(ANGLE_BITS)) u_trig_head (
		.clk(clk), .en(en), .angle(req.heading), .cos_q(ch), .sin_q(sh)
	);
	ptl_cordic #(.ANGLE_BITS(ANGLE_BITS)) u_trig_pan (
		.clk(clk), .en(en), .angle(req.pan_angle), .cos_q(cp), .sin_q(sp)
	);
	ptl_cordic #(.ANGLE_BITS(ANGLE_BITS)) u_trig_tilt (
		.clk(clk), .en(en), .angle(req.tilt_angle), .cos_q(ct), .sin_q(st)
	);

	always_ff @(posedge clk) begin
		if (en) begin
			px_d[0] <= req.pos_x;
			py_d[0] <= req.pos_y;
			rg_d[0] <= req.target_range;
			for (int k = 1; k < CL; k++) begin
				px_d[k] <= px_d[k-1];
				py_d[k] <= py_d[k-1];
				rg_d[k] <= rg_d[k-1];
			end
		end
	end

	// Sensor-frame vector: the range lies along y.
	assign y0 = TS_Y + LW'($signed({1'b0, rg_d[CL-1]}));

	always_ff @(posedge clk) begin
		if (en) begin
			// Tilt products.
			m_yc_s1 <= y0 * ct;
			m_zs_s1 <= TS_Z * st;
			m_ys_s1 <= y0 * st;
			m_zc_s1 <= TS_Z * ct;
			ch_s1 <= ch; sh_s1 <= sh; cp_s1 <= cp; sp_s1 <= sp;
			px_s1 <= px_d[CL-1]; py_s1 <= py_d[CL-1];

			// Tilt sums, then the pan-to-tilt offset.
			ty_s2 <= rnd((PW+1)'(m_yc_s1) + (PW+1)'(m_zs_s1)) + PT_Y;
			tz_s2 <= rnd((PW+1)'(m_zc_s1) - (PW+1)'(m_ys_s1)) + PT_Z;
			ch_s2 <= ch_s1; sh_s2 <= sh_s1; cp_s2 <= cp_s1; sp_s2 <= sp_s1;
			px_s2 <= px_s1; py_s2 <= py_s1;

			// Pan products.
			m_xc_s3 <= TILT_X * cp_s2;
			m_ys_s3 <= ty_s2 * sp_s2;
			m_xs_s3 <= TILT_X * sp_s2;
			m_yc_s3 <= ty_s2 * cp_s2;
			tz_s3 <= tz_s2;
			ch_s3 <= ch_s2; sh_s3 <= sh_s2;
			px_s3 <= px_s2; py_s3 <= py_s2;

			// Pan sums, then the base-to-pan offset.
			qx_s4 <= rnd((PW+1)'(m_xc_s3) + (PW+1)'(m_ys_s3)) + BP_X;
			qy_s4 <= rnd((PW+1)'(m_yc_s3) - (PW+1)'(m_xs_s3)) + BP_Y;
			qz_s4 <= tz_s3 + BP_Z;
			ch_s4 <= ch_s3; sh_s4 <= sh_s3;
			px_s4 <= px_s3; py_s4 <= py_s3;

			// Heading products.
			m_xc_s5 <= qx_s4 * ch_s4;
			m_ys_s5 <= qy_s4 * sh_s4;
			m_xs_s5 <= qx_s4 * sh_s4;
			m_yc_s5 <= qy_s4 * ch_s4;
			qz_s5 <= qz_s4;
			px_s5 <= px_s4; py_s5 <= py_s4;

			// Heading sums plus the base position.
			hx_s6 <= (LW+1)'(rnd((PW+1)'(m_xc_s5) + (PW+1)'(m_ys_s5))) + (LW+1)'(px_s5);
			hy_s6 <= (LW+1)'(rnd((PW+1)'(m_yc_s5) - (PW+1)'(m_xs_s5))) + (LW+1)'(py_s5);
			hz_s6 <= (LW+1)'(qz_s5);

			// Output register.
			rsp.target_x <= sat(hx_s6);
			rsp.target_y <= sat(hy_s6);
			rsp.target_z <= sat(hz_s6);
		end
	end

	// A frozen pipeline keeps its occupancy.
	a_stall_holds: assert property (@(posedge clk) disable iff (!arst_n)
		!en |=> $stable(vld_q))
		else $error("pipeline occupancy changed while stalled");

	// An advancing pipeline shifts its valid bits by exactly one stage.
	a_shift: assert property (@(posedge clk) disable iff (!arst_n)
		en |=> vld_q[NS-1:1] == $past(vld_q[NS-2:0]))
		else $error("valid bits did not move one stage");

	// The first stage is filled only by an accepted word.
	a_entry: assert property (@(posedge clk) disable iff (!arst_n)
		en |=> vld_q[0] == $past(req.valid))
		else $error("first stage valid does not match the accepted word");

endmodule

### tb/testbench.sv
// Self-checking testbench for the pan/tilt target locator: pose words in, world positions out.
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int AB = ptl_pkg::ANGLE_BITS_DEF;
	localparam int LB = ptl_pkg::LENGTH_BITS_DEF;
	localparam int FB = ptl_pkg::LENGTH_FRAC_BITS_DEF;
	localparam int LATENCY = 37;
	localparam int STALL_LIMIT = 2000;
	localparam int N_RANDOM = 1500;

	typedef struct {
		logic signed [LB-1:0] tx;
		logic signed [LB-1:0] ty;
		logic signed [LB-1:0] tz;
	} target_t;

	// Sine and cosine of a binary angle, Q2.30, by the same CORDIC recipe as the block.
	function automatic void sin_cos(input logic [AB-1:0] ang, output longint c,
		output longint s);
		logic [31:0] b;
		logic [31:0] t;
		logic flip;
		longint x, y, z, dx, dy;
		b = {ang, {(32 - AB){1'b0}}};
		t = b + 32'h4000_0000;
		flip = t[31];
		if (flip) begin
			b = b + 32'h8000_0000;
		end
		z = longint'(signed'(b));
		x = 652032874;
		y = 0;
		for (int i = 0; i < 28; i++) begin
			dx = y >>> i;
			dy = x >>> i;
			if (z >= 0) begin
				x -= dx; y += dy; z -= longint'(ptl_pkg::ATAN_TURNS[i]);
			end else begin
				x += dx; y -= dy; z += longint'(ptl_pkg::ATAN_TURNS[i]);
			end
		end
		c = flip ? -x : x;
		s = flip ? -y : y;
	endfunction

	// Offset in 0.1 mm on the length grid, half away from zero.
	function automatic longint offset_len(input int e4);
		longint m;
		longint q;
		m = (e4 < 0 ? -longint'(e4) : longint'(e4)) * (longint'(1) << FB);
		q = (m * 2 + 10000) / 20000;
		return e4 < 0 ? -q : q;
	endfunction

	function automatic longint rot_row(input longint a, input longint ka, input longint b,
		input longint kb);
		return (a * ka + b * kb + (longint'(1) << 29)) >>> 30;
	endfunction

	function automatic logic [LB-1:0] clamp_len(input longint v);
		longint hi;
		longint lo;
		hi = (longint'(1) << (LB - 1)) - 1;
		lo = -(longint'(1) << (LB - 1));
		if (v > hi) v = hi;
		if (v < lo) v = lo;
		return v[LB-1:0];
	endfunction

	function automatic target_t locate_target(input logic signed [LB-1:0] px,
		input logic signed [LB-1:0] py, input logic [AB-1:0] hd, input logic [AB-1:0] pa,
		input logic [AB-1:0] ti, input logic [LB-2:0] rng);
		longint ch, sh, cp, sp, ct, st;
		longint x, y, z, nx, ny, nz;
		target_t r;
		sin_cos(hd, ch, sh);
		sin_cos(pa, cp, sp);
		sin_cos(ti, ct, st);
		x = offset_len(ptl_pkg::TS_X_E4);
		y = offset_len(ptl_pkg::TS_Y_E4) + longint'(rng);
		z = offset_len(ptl_pkg::TS_Z_E4);
		// Tilt about x.
		ny = rot_row(y, ct, z, st);
		nz = rot_row(y, -st, z, ct);
		x = x + offset_len(ptl_pkg::PT_X_E4);
		y = ny + offset_len(ptl_pkg::PT_Y_E4);
		z = nz + offset_len(ptl_pkg::PT_Z_E4);
		// Pan about z.
		nx = rot_row(x, cp, y, sp);
		ny = rot_row(x, -sp, y, cp);
		x = nx + offset_len(ptl_pkg::BP_X_E4);
		y = ny + offset_len(ptl_pkg::BP_Y_E4);
		z = z + offset_len(ptl_pkg::BP_Z_E4);
		// Heading about z, then the base position.
		nx = rot_row(x, ch, y, sh);
		ny = rot_row(x, -sh, y, ch);
		r.tx = clamp_len(nx + longint'(px));
		r.ty = clamp_len(ny + longint'(py));
		r.tz = clamp_len(z);
		return r;
	endfunction

	int n_errors = 0;

	task automatic report_mismatch(input string what);
		$display("ERROR %0t: %s", $realtime, what);
		n_errors++;
	endtask

	// Keeps the targets that accepted words will give, in order.
	class target_board;
		target_t pending[$];

		function void note_word(input logic signed [LB-1:0] px, input logic signed [LB-1:0] py,
			input logic [AB-1:0] hd, input logic [AB-1:0] pa, input logic [AB-1:0] ti,
			input logic [LB-2:0] rng);
			pending.push_back(locate_target(px, py, hd, pa, ti, rng));
		endfunction

		task check_word(input target_t got);
			target_t want;
			if (pending.size() == 0) begin
				report_mismatch("result word with nothing expected");
			end else begin
				want = pending.pop_front();
				if (got.tx !== want.tx)
					report_mismatch($sformatf("target_x %0d, expected %0d", got.tx, want.tx));
				if (got.ty !== want.ty)
					report_mismatch($sformatf("target_y %0d, expected %0d", got.ty, want.ty));
				if (got.tz !== want.tz)
					report_mismatch($sformatf("target_z %0d, expected %0d", got.tz, want.tz));
			end
		endtask
	endclass

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	bit calm = 1'b0;	// Set for the last part of the run: no idling on either side.
	int quiet_cycles = 0;

	ptl_in_if #(.ANGLE_BITS(AB), .LENGTH_BITS(LB)) req ();
	ptl_out_if #(.LENGTH_BITS(LB)) rsp ();

	pan_tilt_target_locate #(
		.ANGLE_BITS(AB),
		.LENGTH_BITS(LB),
		.LENGTH_FRAC_BITS(FB)
	) DUT (
		.clk(clk),
		.arst_n(arst_n),
		.req(req),
		.rsp(rsp)
	);

	target_board board = new();

	initial begin
		forever #1 clk = ~clk;
	end

	// Inputs start at known values; reset is held at first and released once.
	initial begin
		req.valid = 1'b0;
		req.pos_x = '0;
		req.pos_y = '0;
		req.heading = '0;
		req.pan_angle = '0;
		req.tilt_angle = '0;
		req.target_range = '0;
		rsp.ready = 1'b0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
	end

	// Offers one word and holds it until the block takes it. Valid stays high between
	// back-to-back words, so it is never lowered and raised in the same step.
	task automatic send_word(input logic signed [LB-1:0] px, input logic signed [LB-1:0] py,
		input logic [AB-1:0] hd, input logic [AB-1:0] pa, input logic [AB-1:0] ti,
		input logic [LB-2:0] rng);
		int gap;
		if (!calm && $urandom_range(0, 3) == 0) begin
			gap = $urandom_range(1, 18);
			req.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req.valid <= 1'b1;
		req.pos_x <= px;
		req.pos_y <= py;
		req.heading <= hd;
		req.pan_angle <= pa;
		req.tilt_angle <= ti;
		req.target_range <= rng;
		do @(posedge clk); while (!req.ready);
		board.note_word(px, py, hd, pa, ti, rng);
	endtask

	// Angles biased towards the quadrant boundaries, where the pi shift of the CORDIC kicks in.
	function automatic logic [AB-1:0] pick_angle();
		logic [AB-1:0] q;
		if ($urandom_range(0, 3) == 0) begin
			q = AB'($urandom_range(0, 3)) << (AB - 2);
			return q + AB'($urandom_range(0, 4)) - AB'(2);
		end
		return AB'($urandom());
	endfunction

	function automatic logic [LB-1:0] pick_len();
		case ($urandom_range(0, 3))
			0: return LB'($urandom_range(0, 20 << FB)) ^ (LB'($urandom_range(0, 1)) << (LB - 1));
			1: return {1'b0, {(LB - 1){1'b1}}} - LB'($urandom_range(0, 1 << 20));
			2: return {1'b1, {(LB - 1){1'b0}}} + LB'($urandom_range(0, 1 << 20));
			default: return LB'($urandom());
		endcase
	endfunction

	// Sink side: random stalls in bursts, checks every word it takes.
	initial begin
		target_t got;
		int hold;
		@(posedge arst_n);
		forever begin
			if (!calm && $urandom_range(0, 3) == 0) begin
				hold = $urandom_range(1, 18);
				rsp.ready <= 1'b0;
				repeat (hold) @(posedge clk);
			end
			rsp.ready <= 1'b1;
			@(posedge clk);
			if (rsp.valid && rsp.ready) begin
				got.tx = rsp.target_x;
				got.ty = rsp.target_y;
				got.tz = rsp.target_z;
				board.check_word(got);
			end
		end
	end

	// Watchdog: counts cycles in which no word moves on either channel.
	initial begin
		forever begin
			@(posedge clk);
			if ((req.valid && req.ready) || (rsp.valid && rsp.ready))
				quiet_cycles = 0;
			else
				quiet_cycles++;
			if (quiet_cycles >= STALL_LIMIT) begin
				$display("watchdog: no progress for %0d cycles", STALL_LIMIT);
				$display("pan_tilt_target_locate: mismatch");
				$finish;
			end
		end
	end

	initial begin
		logic [AB-1:0] angle_set[8];
		int waited;
		angle_set = '{16'h0000, 16'h4000, 16'h8000, 16'hC000, 16'h3FFF, 16'h7FFF, 16'hBFFF,
			16'hFFFF};
		@(posedge arst_n);
		@(posedge clk);

		// Directed: extreme positions and ranges, all quadrant boundaries, saturation.
		send_word('0, '0, '0, '0, '0, '0);
		send_word({1'b0, {(LB - 1){1'b1}}}, {1'b0, {(LB - 1){1'b1}}}, '0, '0, '0,
			{(LB - 1){1'b1}});
		send_word({1'b1, {(LB - 1){1'b0}}}, {1'b1, {(LB - 1){1'b0}}}, 16'h8000, '0, '0,
			{(LB - 1){1'b1}});
		send_word({1'b1, {(LB - 1){1'b0}}}, {1'b0, {(LB - 1){1'b1}}}, 16'h4000, 16'h4000,
			16'h4000, {(LB - 1){1'b1}});
		send_word({1'b0, {(LB - 1){1'b1}}}, {1'b1, {(LB - 1){1'b0}}}, 16'hC000, 16'hC000,
			16'hC000, {(LB - 1){1'b1}});
		for (int i = 0; i < 8; i++)
			send_word(LB'(i << FB), -LB'(i << FB), angle_set[i], angle_set[7 - i],
				angle_set[(i + 3) % 8], (LB - 1)'(1 << FB) + (LB - 1)'(i));
		for (int i = 0; i < 8; i++)
			send_word('0, '0, '0, '0, angle_set[i], (LB - 1)'($urandom_range(0, 5 << FB)));
		send_word('0, '0, 16'h7FFF, 16'h8001, 16'h0001, '0);

		// Random part; the last stretch runs with no idling on either side.
		for (int n = 0; n < N_RANDOM; n++) begin
			if (n == N_RANDOM - 200)
				calm = 1'b1;
			send_word(pick_len(), pick_len(),
				pick_angle(), pick_angle(), pick_angle(), (LB - 1)'(pick_len()));
		end
		req.valid <= 1'b0;

		waited = 0;
		while (board.pending.size() != 0 && waited < 100000) begin
			@(posedge clk);
			waited++;
		end
		repeat (2 * LATENCY) @(posedge clk);
		if (board.pending.size() != 0)
			report_mismatch($sformatf("%0d results never arrived", board.pending.size()));
		if (n_errors == 0) begin
			$display("pan_tilt_target_locate: match");
		end else begin
			$display("pan_tilt_target_locate: mismatch");
		end
		$finish;
	end
endmodule

### pan_tilt_target_locate.f
rtl/ptl_pkg.sv
rtl/ptl_in_if.sv
rtl/ptl_out_if.sv
rtl/ptl_cordic.sv
rtl/pan_tilt_target_locate.sv
tb/testbench.sv
